// ----- rtl/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants of the text line segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

  localparam int MAX_ROWS_DEF        = 2048;
  localparam int MAX_LINE_HEIGHT_DEF = 16;
  localparam int KEY_COLOURS_DEF     = 8;

  localparam int KEY_REGS   = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 25;
  localparam int KEY_EN_BIT = 24;
  localparam int OUT_ROW_W  = 11;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef logic [OUT_ROW_W-1:0] brow_t;

  // one boundary result
  typedef struct packed {
    brow_t row;
    logic  start;
  } res_t;

  // everything one pixel causes: one or two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } evt_t;

  // queue head as seen by the back end
  typedef struct packed {
    evt_t evt;
    logic empty;
  } qhead_t;

endpackage

`default_nettype wire

// ----- rtl/tls_front.sv -----
// ----------------------------------------------------------------------------
// tls_front
// Key colour registers, pixel classification and line tracking; packs the
// boundaries caused by one pixel into one event.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_front #(
  parameter int MAX_ROWS        = tls_pkg::MAX_ROWS_DEF,
  parameter int MAX_LINE_HEIGHT = tls_pkg::MAX_LINE_HEIGHT_DEF,
  parameter int KEY_COLOURS     = tls_pkg::KEY_COLOURS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          accept,
  input  wire logic [7:0]                    pixel_red,
  input  wire logic [7:0]                    pixel_green,
  input  wire logic [7:0]                    pixel_blue,
  input  wire logic                          row_end,
  input  wire logic                          frame_end,
  output tls_pkg::evt_t                      evt,
  output logic                               evt_push
);

  localparam int ROW_W = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int HT_W  = $clog2(MAX_LINE_HEIGHT + 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [HT_W-1:0]  HT_MAX   = HT_W'(MAX_LINE_HEIGHT);

  logic [tls_pkg::CFG_DATA_W-1:0] key_r [tls_pkg::KEY_REGS];
  logic [KEY_COLOURS-1:0]         hit;
  logic                           text;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic             at_start_r, at_start_nxt;
  logic             open_r, open_nxt;
  logic [HT_W-1:0]  height_r, height_nxt;
  logic             has_text_r, has_text_nxt;

  logic [ROW_W-1:0] prev_row;
  logic             row_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tls_pkg::KEY_REGS; k++) key_r[k] <= '0;
    end else if (cfg_we && cfg_index < tls_pkg::CFG_IDX_W'(tls_pkg::KEY_REGS)) begin
      key_r[cfg_index[tls_pkg::KEY_IDX_W-1:0]] <= cfg_data;
    end
  end

  for (genvar k = 0; k < KEY_COLOURS; k++) begin : g_key
    assign hit[k] = key_r[k][tls_pkg::KEY_EN_BIT] &&
                    key_r[k][tls_pkg::KEY_EN_BIT-1:0] == {pixel_red, pixel_green, pixel_blue};
  end
  assign text = |hit;

  assign prev_row = (row_r == '0) ? ROW_LAST : row_r - ROW_W'(1);
  assign row_done = row_end || frame_end;

  always_comb begin
    logic            has0, open0, hclose, opened, open1, has1, bclose, open2;
    logic            fclose, drop, got0;
    logic [HT_W-1:0] h0, h1;
    logic [3:0]      c_v;
    tls_pkg::res_t   c [4];

    has0   = at_start_r ? 1'b0 : has_text_r;
    open0  = open_r;
    h0     = height_r;
    h1     = height_r;
    hclose = 1'b0;
    if (at_start_r && open_r) begin
      h1 = (height_r < HT_MAX) ? height_r + HT_W'(1) : height_r;
      if (h1 >= HT_MAX) begin
        hclose = 1'b1;
        open0  = 1'b0;
        h0     = '0;
      end else begin
        h0 = h1;
      end
    end

    opened = text && !open0;
    open1  = open0 || text;
    has1   = has0 || text;
    if (opened) h0 = '0;

    // a whole row without text closes the line at the row before
    bclose = row_done && !has1 && open1;
    open2  = open1 && !bclose;
    fclose = frame_end && open2;
    // height close plus a one-row line at frame end: drop the one-row line
    drop   = frame_end && hclose && opened;

    c_v[0] = hclose;
    c[0]   = '{row: tls_pkg::brow_t'(prev_row), start: 1'b0};
    c_v[1] = opened && !drop;
    c[1]   = '{row: tls_pkg::brow_t'(row_r), start: 1'b1};
    c_v[2] = bclose;
    c[2]   = '{row: tls_pkg::brow_t'(prev_row), start: 1'b0};
    c_v[3] = fclose && !drop;
    c[3]   = '{row: tls_pkg::brow_t'(row_r), start: 1'b0};

    evt  = '0;
    got0 = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (c_v[i]) begin
        if (!got0) begin
          evt.r0 = c[i];
          got0   = 1'b1;
        end else begin
          evt.r1  = c[i];
          evt.two = 1'b1;
        end
      end
    end
    evt_push = accept && (c_v != '0);

    if (row_done) begin
      row_nxt      = frame_end ? '0 : ((row_r == ROW_LAST) ? '0 : row_r + ROW_W'(1));
      at_start_nxt = 1'b1;
      open_nxt     = frame_end ? 1'b0 : open2;
      height_nxt   = (frame_end || bclose) ? '0 : h0;
      has_text_nxt = 1'b0;
    end else begin
      row_nxt      = row_r;
      at_start_nxt = 1'b0;
      open_nxt     = open1;
      height_nxt   = h0;
      has_text_nxt = has1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      at_start_r <= 1'b1;
      open_r     <= 1'b0;
      height_r   <= '0;
      has_text_r <= 1'b0;
    end else if (accept) begin
      row_r      <= row_nxt;
      at_start_r <= at_start_nxt;
      open_r     <= open_nxt;
      height_r   <= height_nxt;
      has_text_r <= has_text_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tls_queue.sv -----
// ----------------------------------------------------------------------------
// tls_queue
// Short event queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tls_pkg::evt_t  push_evt,
  output logic                full,
  input  wire logic           pop,
  output tls_pkg::qhead_t     head
);

  tls_pkg::evt_t                mem_r [tls_pkg::QDEPTH];
  logic [tls_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tls_pkg::QPTR_W:0]     cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full       = cnt_r == (tls_pkg::QPTR_W+1)'(tls_pkg::QDEPTH);
  assign head.empty = cnt_r == '0;
  assign head.evt   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !head.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tls_back.sv -----
// ----------------------------------------------------------------------------
// tls_back
// Back end: hands out the one or two results of the head event in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tls_pkg::qhead_t               head,
  output logic                               head_pop,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [tls_pkg::OUT_ROW_W-1:0]      out_boundary_row,
  output logic                               out_is_line_start,
  output logic                               out_last_of_run
);

  logic          sel_r;
  tls_pkg::res_t cur;
  logic          beat;

  assign cur               = sel_r ? head.evt.r1 : head.evt.r0;
  assign out_empty         = head.empty;
  assign out_boundary_row  = cur.row;
  assign out_is_line_start = cur.start;
  assign out_last_of_run   = sel_r || !head.evt.two;
  assign beat              = out_pop && !head.empty;
  assign head_pop          = beat && out_last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (beat) begin
      sel_r <= !out_last_of_run;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_line_segmenter.sv -----
// ----------------------------------------------------------------------------
// text_line_segmenter
// Finds the top and bottom rows of text lines in a raster RGB stream.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in_       input      in_push / in_full  pixel_red/green/blue, row_end, frame_end
// out_      output     out_pop / out_empty boundary_row, is_line_start, last_of_run
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel a cycle is taken while the event queue has room; classification
// and line tracking finish in the cycle the pixel is accepted.
// a pixel gives zero, one or two results; the back end hands out one result
// a cycle while out_pop is high, so pixels giving two results take two pops.
// the four-entry event queue lets the front keep taking pixels while results
// wait; in_full rises only when the queue holds four events.
// synchronous reset clears the key registers, line state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_segmenter #(
  parameter int MAX_ROWS        = tls_pkg::MAX_ROWS_DEF,
  parameter int MAX_LINE_HEIGHT = tls_pkg::MAX_LINE_HEIGHT_DEF,
  parameter int KEY_COLOURS     = tls_pkg::KEY_COLOURS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [7:0]                     in_pixel_red,
  input  wire logic [7:0]                     in_pixel_green,
  input  wire logic [7:0]                     in_pixel_blue,
  input  wire logic                           in_row_end,
  input  wire logic                           in_frame_end,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [tls_pkg::OUT_ROW_W-1:0]       out_boundary_row,
  output logic                                out_is_line_start,
  output logic                                out_last_of_run,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0] cfg_data
);

  tls_pkg::evt_t   evt;
  logic            evt_push;
  logic            head_pop;
  tls_pkg::qhead_t head;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  tls_front #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_LINE_HEIGHT (MAX_LINE_HEIGHT),
    .KEY_COLOURS     (KEY_COLOURS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel_red   (in_pixel_red),
    .pixel_green (in_pixel_green),
    .pixel_blue  (in_pixel_blue),
    .row_end     (in_row_end),
    .frame_end   (in_frame_end),
    .evt         (evt),
    .evt_push    (evt_push)
  );

  tls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (evt_push),
    .push_evt (evt),
    .full     (in_full),
    .pop      (head_pop),
    .head     (head)
  );

  tls_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .head_pop          (head_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_boundary_row  (out_boundary_row),
    .out_is_line_start (out_is_line_start),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- rtl/tls_checker.sv -----
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks of the text line segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_full,
  input wire logic                         out_empty,
  input wire logic                         out_pop,
  input wire logic [tls_pkg::OUT_ROW_W-1:0] out_boundary_row,
  input wire logic                         out_is_line_start,
  input wire logic                         out_last_of_run
);

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_boundary_row) &&
      $stable(out_is_line_start) && $stable(out_last_of_run)))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("results present after reset");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("queue full but no result shown");

  // a top that is not last of its beat run is a one-row line closed at frame end
  a_top_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_is_line_start && !out_last_of_run) |=>
      (!out_empty && !out_is_line_start && out_last_of_run &&
       out_boundary_row == $past(out_boundary_row)))
    else $error("line top not followed by its bottom");

endmodule

bind text_line_segmenter tls_checker u_tls_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_boundary_row  (out_boundary_row),
  .out_is_line_start (out_is_line_start),
  .out_last_of_run   (out_last_of_run)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text line segmenter: a clocked driver pushes
// pixels from a pending queue, a line tracker predicts the boundary rows of
// every accepted pixel, and a clocked monitor compares each popped result.
// ----------------------------------------------------------------------------

module testbench;

  localparam int          HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CFG_SLOTS     = 1 << tls_pkg::CFG_IDX_W;
  localparam logic [24:0] KEY_EN        = 25'(1) << tls_pkg::KEY_EN_BIT;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    tls_pkg::brow_t row;
    logic           top;
    logic           last_one;
  } boundary_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_push        = 1'b0;
  logic [7:0]  in_pixel_red   = '0;
  logic [7:0]  in_pixel_green = '0;
  logic [7:0]  in_pixel_blue  = '0;
  logic        in_row_end     = 1'b0;
  logic        in_frame_end   = 1'b0;
  logic        out_pop        = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tls_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  wire         in_full;
  wire         out_empty;
  wire [tls_pkg::OUT_ROW_W-1:0] out_boundary_row;
  wire         out_is_line_start;
  wire         out_last_of_run;
  wire         cfg_ready;

  text_line_segmenter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .in_row_end        (in_row_end),
    .in_frame_end      (in_frame_end),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_boundary_row  (out_boundary_row),
    .out_is_line_start (out_is_line_start),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // pixels waiting to be pushed and boundaries waiting to be popped
  pixel_t    pending_q[$];
  boundary_t boundary_q[$];

  // line tracker state
  logic [24:0] key_regs[tls_pkg::KEY_REGS];
  logic [24:0] key_plan[tls_pkg::KEY_REGS];
  int  cur_row      = 0;
  bit  at_row_start = 1'b1;
  bit  line_open    = 1'b0;
  int  line_height  = 0;
  bit  row_text     = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int err_cnt        = 0;
  int queued         = 0;
  int pixels_taken   = 0;
  int results_popped = 0;
  int frames_done    = 0;
  int limit_closes   = 0;
  int double_runs    = 0;
  int cfg_writes     = 0;

  initial begin
    for (int k = 0; k < tls_pkg::KEY_REGS; k++) key_regs[k] = '0;
  end

  function automatic bit is_text_rgb(logic [23:0] rgb);
    for (int k = 0; k < tls_pkg::KEY_COLOURS_DEF && k < tls_pkg::KEY_REGS; k++)
      if (key_regs[k][tls_pkg::KEY_EN_BIT] && key_regs[k][23:0] == rgb) return 1'b1;
    return 1'b0;
  endfunction

  // expected boundaries of one accepted pixel
  function automatic void track_lines(pixel_t px);
    boundary_t      run[3];
    int             n;
    bit             text;
    bit             hclosed;
    bit             opened;
    tls_pkg::brow_t prev;
    n       = 0;
    hclosed = 1'b0;
    opened  = 1'b0;
    text    = is_text_rgb({px.red, px.green, px.blue});
    prev    = tls_pkg::brow_t'((cur_row + tls_pkg::MAX_ROWS_DEF - 1) %
                               tls_pkg::MAX_ROWS_DEF);
    if (at_row_start) begin
      row_text = 1'b0;
      if (line_open) begin
        if (line_height < tls_pkg::MAX_LINE_HEIGHT_DEF) line_height++;
        if (line_height >= tls_pkg::MAX_LINE_HEIGHT_DEF) begin
          run[n]      = '{prev, 1'b0, 1'b0};
          n++;
          line_open   = 1'b0;
          line_height = 0;
          hclosed     = 1'b1;
          limit_closes++;
        end
      end
      at_row_start = 1'b0;
    end
    if (text) begin
      row_text = 1'b1;
      if (!line_open) begin
        run[n]      = '{tls_pkg::brow_t'(cur_row), 1'b1, 1'b0};
        n++;
        line_open   = 1'b1;
        line_height = 0;
        opened      = 1'b1;
      end
    end
    if (px.row_end || px.frame_end) begin
      if (!row_text && line_open) begin
        run[n]      = '{prev, 1'b0, 1'b0};
        n++;
        line_open   = 1'b0;
        line_height = 0;
      end
      if (px.frame_end && line_open) begin
        // a one-row line opened right after a height-limit close is dropped
        if (hclosed && opened) begin
          n--;
        end else begin
          run[n] = '{tls_pkg::brow_t'(cur_row), 1'b0, 1'b0};
          n++;
        end
        line_open   = 1'b0;
        line_height = 0;
      end
      if (px.frame_end) begin
        cur_row     = 0;
        line_height = 0;
        line_open   = 1'b0;
        frames_done++;
      end else begin
        cur_row = (cur_row + 1) % tls_pkg::MAX_ROWS_DEF;
      end
      at_row_start = 1'b1;
      row_text     = 1'b0;
    end
    if (n > 0) run[n-1].last_one = 1'b1;
    if (n > 1) double_runs++;
    for (int i = 0; i < n; i++) boundary_q = {boundary_q, run[i]};
  endfunction

  // pixel driver
  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        track_lines(pending_q.pop_front());
        pixels_taken++;
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q[0];
        in_push        <= 1'b1;
        in_pixel_red   <= nxt.red;
        in_pixel_green <= nxt.green;
        in_pixel_blue  <= nxt.blue;
        in_row_end     <= nxt.row_end;
        in_frame_end   <= nxt.frame_end;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk) begin : take_results
    boundary_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_popped++;
        if (boundary_q.size() == 0) begin
          $error("unexpected result: boundary_row %0d, is_line_start %0b",
                 out_boundary_row, out_is_line_start);
          err_cnt++;
        end else begin
          want = boundary_q.pop_front();
          if (out_boundary_row !== want.row) begin
            $error("boundary_row: expected %0d, actual %0d", want.row, out_boundary_row);
            err_cnt++;
          end
          if (out_is_line_start !== want.top) begin
            $error("is_line_start: expected %0b, actual %0b", want.top, out_is_line_start);
            err_cnt++;
          end
          if (out_last_of_run !== want.last_one) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_one, out_last_of_run);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_req != hold_seen) begin
        // long back-pressure so the event queue fills and in_full rises
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, boundary_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // writes key_plan to the key registers and junk to the unused slots
  task automatic program_keys();
    for (int k = 0; k < CFG_SLOTS; k++) begin
      cfg_index <= tls_pkg::CFG_IDX_W'(k);
      cfg_data  <= (k < tls_pkg::KEY_REGS) ? key_plan[k] :
                                             tls_pkg::CFG_DATA_W'($urandom);
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      if (k < tls_pkg::KEY_REGS) key_regs[k] = key_plan[k];
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_plan();
    for (int k = 0; k < tls_pkg::KEY_REGS; k++)
      key_plan[k] = {($urandom_range(3) != 0), 24'($urandom)};
  endtask

  task automatic settle();
    do @(posedge clk); while (pending_q.size() != 0 || in_push);
    while (boundary_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(logic [23:0] rgb, logic re, logic fe);
    pixel_t px;
    px.red       = rgb[23:16];
    px.green     = rgb[15:8];
    px.blue      = rgb[7:0];
    px.row_end   = re;
    px.frame_end = fe;
    pending_q    = {pending_q, px};
    queued++;
  endtask

  function automatic logic [23:0] plain_colour();
    logic [23:0] rgb;
    case ($urandom_range(7))
      0:       rgb = key_regs[$urandom_range(tls_pkg::KEY_REGS-1)][23:0];
      1:       rgb = '0;
      2:       rgb = '1;
      default: rgb = 24'($urandom);
    endcase
    while (is_text_rgb(rgb)) rgb = 24'($urandom);
    return rgb;
  endfunction

  function automatic logic [23:0] text_colour();
    logic [23:0] pick[$];
    for (int k = 0; k < tls_pkg::KEY_COLOURS_DEF && k < tls_pkg::KEY_REGS; k++)
      if (key_regs[k][tls_pkg::KEY_EN_BIT]) pick = {pick, key_regs[k][23:0]};
    if (pick.size() == 0) return plain_colour();
    return pick[$urandom_range(pick.size()-1)];
  endfunction

  // raster frame built from text bands and blank gaps
  task automatic gen_frame();
    int width;
    int rows;
    int len;
    int hit;
    int band_left;
    int gap_left;
    bit text_row;
    bit last_row;
    width     = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6);
    rows      = $urandom_range(1, 45);
    band_left = 0;
    gap_left  = $urandom_range(0, 2);
    for (int r = 0; r < rows; r++) begin
      if (band_left > 0) begin
        text_row = 1'b1;
        band_left--;
      end else if (gap_left > 0) begin
        text_row = 1'b0;
        gap_left--;
      end else begin
        text_row  = 1'b1;
        band_left = $urandom_range(1, 20) - 1;
        gap_left  = $urandom_range(0, 3);
      end
      last_row = (r == rows - 1);
      len      = last_row ? $urandom_range(1, width) : width;
      hit      = $urandom_range(len - 1);
      for (int c = 0; c < len; c++) begin
        push_pixel((text_row && (c == hit || $urandom_range(2) == 0)) ?
                   text_colour() : plain_colour(),
                   (c == len - 1) && (!last_row || $urandom_range(1)),
                   last_row && (c == len - 1));
      end
    end
  endtask

  // unstructured pixels with random marks
  task automatic gen_noise();
    int n;
    n = $urandom_range(5, 20);
    for (int i = 0; i < n; i++)
      push_pixel(($urandom_range(2) == 0) ? text_colour() : plain_colour(),
                 ($urandom_range(3) == 0), ($urandom_range(11) == 0));
  endtask

  task automatic gen_random(int target);
    int start;
    start = queued;
    while (queued - start < target) begin
      if ($urandom_range(7) == 0) gen_noise();
      else gen_frame();
    end
  endtask

  task automatic directed_frames();
    // sixteen text rows, then a lone text pixel that ends the frame
    for (int r = 0; r < tls_pkg::MAX_LINE_HEIGHT_DEF; r++)
      push_pixel(24'h000000, 1'b1, 1'b0);
    push_pixel(24'hFFFFFF, 1'b1, 1'b1);
    // frame end without row end closes the open line
    push_pixel(24'h123456, 1'b0, 1'b0);
    push_pixel(24'hFF00FF, 1'b0, 1'b1);
    // disabled key colour, one-row line, then top and bottom on one pixel
    push_pixel(24'hABCDEF, 1'b1, 1'b0);
    push_pixel(24'hFFFFFF, 1'b1, 1'b0);
    push_pixel(24'h00FF01, 1'b1, 1'b0);
    push_pixel(24'h000000, 1'b1, 1'b1);
    // empty single-pixel frame
    push_pixel(24'h7F7F7F, 1'b1, 1'b1);
  endtask

  initial begin : run_test
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 76;
    key_plan[0] = KEY_EN | 25'h000000;
    key_plan[1] = KEY_EN | 25'hFFFFFF;
    key_plan[2] = KEY_EN | 25'h123456;
    key_plan[3] = 25'h0ABCDEF;
    key_plan[4] = KEY_EN | 25'h00FF00;
    key_plan[5] = '0;
    key_plan[6] = KEY_EN | 25'h800001;
    key_plan[7] = '1;
    program_keys();
    directed_frames();
    settle();

    random_plan();
    program_keys();
    gen_random(250);
    hold_req++;
    settle();

    send_idle_pct = 76;
    recv_idle_pct = 13;
    for (int k = 0; k < tls_pkg::KEY_REGS; k++) key_plan[k] = '0;
    program_keys();
    gen_random(40);
    settle();
    for (int k = 0; k < tls_pkg::KEY_REGS; k++) key_plan[k] = '1;
    program_keys();
    gen_random(250);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_plan();
    program_keys();
    gen_random(220);
    hold_req++;
    settle();

    $display("covered %0d pixels in %0d frames, %0d boundaries checked, %0d key writes",
             pixels_taken, frames_done, results_popped, cfg_writes);
    $display("height-limit closes %0d, pixels with two boundaries %0d, mismatches %0d",
             limit_closes, double_runs, err_cnt);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
